// ===== rtl/fixed_point_q24_8_alu_top_defines.svh =====
// ----------------------------------------------------------------------------
// fixed-point alu assertion macros
// clocked assertion helpers used by the alu top level
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_Q24_8_ALU_TOP_DEFINES_SVH
`define FIXED_POINT_Q24_8_ALU_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// property must hold at every edge outside reset
`define FPA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// expression must never be true outside reset
`define FPA_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define FPA_ASSERT(lbl, clk, rst, prop, msg)
`define FPA_ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

// ===== rtl/fpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fpa_pkg
// shared codes and types of the q24.8 fixed-point alu
// ----------------------------------------------------------------------------
package fpa_pkg;

   localparam int FPA_FRAC_BITS_DEF = 8;

   localparam logic [3:0] OP_ADD = 4'd0;
   localparam logic [3:0] OP_SUB = 4'd1;
   localparam logic [3:0] OP_MUL = 4'd2;
   localparam logic [3:0] OP_DIV = 4'd3;
   localparam logic [3:0] OP_MIN = 4'd4;
   localparam logic [3:0] OP_MAX = 4'd5;
   localparam logic [3:0] OP_INC = 4'd6;
   localparam logic [3:0] OP_DEC = 4'd7;
   localparam logic [3:0] OP_I2F = 4'd8;
   localparam logic [3:0] OP_F2I = 4'd9;

   // item fields that ride alongside the divider
   typedef struct packed {
      logic [3:0]  kind;
      logic        lt;
      logic        eq;
      logic        gt;
      logic [31:0] res_simple;
      logic        neg;
      logic        dbz;
      logic [31:0] mul_res;
      logic        mul_ovf;
   } side_type;

endpackage

// ===== rtl/fpa_mul.sv =====
// ----------------------------------------------------------------------------
// fpa_mul
// two-stage signed multiply with ceiling shift and saturation
// ----------------------------------------------------------------------------
module fpa_mul #(
   parameter int FRAC_BITS = fpa_pkg::FPA_FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   output logic [31:0] mul_res,
   output logic        mul_ovf
);
   import fpa_pkg::*;

   localparam logic [63:0] RND = 64'((64'd1 << FRAC_BITS) - 64'd1);

   logic signed [63:0] prod_ff, prod_in;
   logic signed [63:0] rnd_sum, shifted;
   logic [31:0] res_ff, res_in;
   logic        ovf_ff, ovf_in;

   assign prod_in = $signed(op_a) * $signed(op_b);

   // floor of (p + 2^f - 1) / 2^f is the ceiling of p / 2^f
   always_comb begin
      rnd_sum = prod_ff + $signed(RND);
      shifted = rnd_sum >>> FRAC_BITS;
      if (shifted > 64'sd2147483647) begin
         res_in = 32'h7FFF_FFFF;
         ovf_in = 1'b1;
      end else if (shifted < -64'sd2147483648) begin
         res_in = 32'h8000_0000;
         ovf_in = 1'b1;
      end else begin
         res_in = shifted[31:0];
         ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         res_ff  <= res_in;
         ovf_ff  <= ovf_in;
      end
   end

   assign mul_res = res_ff;
   assign mul_ovf = ovf_ff;

endmodule

// ===== rtl/fpa_div_step.sv =====
// ----------------------------------------------------------------------------
// fpa_div_step
// one restoring-division stage: one quotient bit per register stage
// ----------------------------------------------------------------------------
module fpa_div_step #(
   parameter int NUM_W = 40
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_vld,
   input  logic [31:0]          in_rem,
   input  logic [NUM_W-1:0]     in_nq,
   input  logic [31:0]          in_dvs,
   input  fpa_pkg::side_type    in_side,
   output logic                 out_vld,
   output logic [31:0]          out_rem,
   output logic [NUM_W-1:0]     out_nq,
   output logic [31:0]          out_dvs,
   output fpa_pkg::side_type    out_side
);
   import fpa_pkg::*;

   logic             vld_ff;
   logic [31:0]      rem_ff, rem_in;
   logic [NUM_W-1:0] nq_ff, nq_in;
   logic [31:0]      dvs_ff;
   side_type         side_ff;
   logic [32:0]      trial, diff;
   logic             take;

   // numerator bits leave at the top, quotient bits enter at the bottom
   always_comb begin
      trial  = {in_rem, in_nq[NUM_W-1]};
      diff   = trial - {1'b0, in_dvs};
      take   = (trial >= {1'b0, in_dvs});
      rem_in = take ? diff[31:0] : trial[31:0];
      nq_in  = {in_nq[NUM_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         nq_ff   <= nq_in;
         dvs_ff  <= in_dvs;
         side_ff <= in_side;
      end
   end

   assign out_vld  = vld_ff;
   assign out_rem  = rem_ff;
   assign out_nq   = nq_ff;
   assign out_dvs  = dvs_ff;
   assign out_side = side_ff;

endmodule

// ===== rtl/fixed_point_q24_8_alu_top.sv =====
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_top
// pipelined q24.8 fixed-point alu: wrap-around add/sub, ceiling mul and div
// with saturation, min/max, format shifts and signed compare flags
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                                    | tuser
//  --------+-----+------------------------------------------+-----------
//  req     | in  | [31:0] operand_a, [63:32] operand_b      | [3:0] kind
//  rsp     | out | [31:0] result_raw, lt, eq, gt, ovf, dbz  | -
//
//  one transfer accepted per cycle unless the output stalls; the divider
//  resolves one quotient bit per stage
//  every operation travels the same pipeline, so results leave in order
//  the whole pipeline advances together whenever the output register is free
//  or being taken; a stall freezes every stage and nothing is lost
//  synchronous active-high reset clears the valid bits only
//
`include "fixed_point_q24_8_alu_top_defines.svh"

module fixed_point_q24_8_alu_top #(
   parameter int FRAC_BITS = fpa_pkg::FPA_FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] operand_a, [63:32] operand_b
   input  logic [3:0]  req_tuser,   // [3:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] result_raw, [32] less_than, [33] equal_to, [34] greater_than,
   // [35] overflow, [36] divide_by_zero, [39:37] zero
   output logic [39:0] rsp_tdata
);
   import fpa_pkg::*;

   // numerator width: |a| shifted up by the fraction bits
   localparam int NUM_W = 32 + FRAC_BITS;

   logic pipe_en;

   // ---------------- stage 1: decode, compare, simple ops, divider setup
   logic [31:0] op_a, op_b;
   logic [31:0] abs_a, abs_b;
   side_type    s1_side_in;
   logic        s1_vld_ff;
   side_type    s1_side_ff;
   logic [NUM_W-1:0] s1_nq_ff;
   logic [31:0] s1_dvs_ff;

   assign op_a = req_tdata[31:0];
   assign op_b = req_tdata[63:32];

   always_comb begin
      abs_a = op_a[31] ? (32'd0 - op_a) : op_a;
      abs_b = op_b[31] ? (32'd0 - op_b) : op_b;
      s1_side_in.kind    = req_tuser;
      s1_side_in.lt      = ($signed(op_a) < $signed(op_b));
      s1_side_in.eq      = (op_a == op_b);
      s1_side_in.gt      = ($signed(op_a) > $signed(op_b));
      s1_side_in.neg     = op_a[31] ^ op_b[31];
      s1_side_in.dbz     = (op_b == 32'd0);
      s1_side_in.mul_res = 32'd0;
      s1_side_in.mul_ovf = 1'b0;
      case (req_tuser)
         OP_ADD:  s1_side_in.res_simple = op_a + op_b;
         OP_SUB:  s1_side_in.res_simple = op_a - op_b;
         OP_MIN:  s1_side_in.res_simple = s1_side_in.lt ? op_a : op_b;
         OP_MAX:  s1_side_in.res_simple = s1_side_in.gt ? op_a : op_b;
         OP_INC:  s1_side_in.res_simple = op_a + 32'd1;
         OP_DEC:  s1_side_in.res_simple = op_a - 32'd1;
         OP_I2F:  s1_side_in.res_simple = op_a << FRAC_BITS;
         OP_F2I:  s1_side_in.res_simple = 32'($signed(op_a) >>> FRAC_BITS);
         default: s1_side_in.res_simple = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_side_ff <= s1_side_in;
         s1_nq_ff   <= {abs_a, {FRAC_BITS{1'b0}}};
         s1_dvs_ff  <= abs_b;
      end
   end

   // multiplier runs beside stages 1 and 2
   logic [31:0] mul_res;
   logic        mul_ovf;

   fpa_mul #(
      .FRAC_BITS(FRAC_BITS)
   ) u_mul (
      .clock  (clock),
      .en     (pipe_en),
      .op_a   (op_a),
      .op_b   (op_b),
      .mul_res(mul_res),
      .mul_ovf(mul_ovf)
   );

   // ---------------- stage 2: carry the item while the multiply finishes
   logic        s2_vld_ff;
   side_type    s2_side_ff;
   logic [NUM_W-1:0] s2_nq_ff;
   logic [31:0] s2_dvs_ff;
   side_type    s2_side;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (pipe_en) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s2_side_ff <= s1_side_ff;
         s2_nq_ff   <= s1_nq_ff;
         s2_dvs_ff  <= s1_dvs_ff;
      end
   end

   always_comb begin
      s2_side         = s2_side_ff;
      s2_side.mul_res = mul_res;
      s2_side.mul_ovf = mul_ovf;
   end

   // ---------------- divider chain: one quotient bit per stage
   logic             dv_vld  [NUM_W+1];
   logic [31:0]      dv_rem  [NUM_W+1];
   logic [NUM_W-1:0] dv_nq   [NUM_W+1];
   logic [31:0]      dv_dvs  [NUM_W+1];
   side_type         dv_side [NUM_W+1];

   assign dv_vld[0]  = s2_vld_ff;
   assign dv_rem[0]  = 32'd0;
   assign dv_nq[0]   = s2_nq_ff;
   assign dv_dvs[0]  = s2_dvs_ff;
   assign dv_side[0] = s2_side;

   for (genvar gi = 0; gi < NUM_W; gi++) begin : g_div
      fpa_div_step #(
         .NUM_W(NUM_W)
      ) u_step (
         .clock   (clock),
         .reset   (reset),
         .en      (pipe_en),
         .in_vld  (dv_vld[gi]),
         .in_rem  (dv_rem[gi]),
         .in_nq   (dv_nq[gi]),
         .in_dvs  (dv_dvs[gi]),
         .in_side (dv_side[gi]),
         .out_vld (dv_vld[gi+1]),
         .out_rem (dv_rem[gi+1]),
         .out_nq  (dv_nq[gi+1]),
         .out_dvs (dv_dvs[gi+1]),
         .out_side(dv_side[gi+1])
      );
   end

   // ---------------- final stage: ceiling fix-up, saturation, result select
   side_type         fin_side;
   logic [NUM_W-1:0] quo;
   logic [NUM_W:0]   pos_q;
   logic [31:0]      div_res;
   logic             div_ovf;
   logic [31:0]      res_sel;
   logic             ovf_sel;
   logic             dbz_sel;
   logic             rsp_vld_ff;
   logic [36:0]      rsp_data_ff, rsp_data_in;

   assign fin_side = dv_side[NUM_W];
   assign quo      = dv_nq[NUM_W];

   always_comb begin
      // positive quotient rounds up on any remainder, negative truncates
      pos_q = {1'b0, quo} + (NUM_W+1)'(dv_rem[NUM_W] != 32'd0);
      if (fin_side.neg) begin
         div_ovf = (quo > {{(NUM_W-32){1'b0}}, 32'h8000_0000});
         div_res = div_ovf ? 32'h8000_0000 : (32'd0 - quo[31:0]);
      end else begin
         div_ovf = (pos_q > {{(NUM_W-31){1'b0}}, 32'h7FFF_FFFF});
         div_res = div_ovf ? 32'h7FFF_FFFF : pos_q[31:0];
      end

      ovf_sel = 1'b0;
      dbz_sel = 1'b0;
      case (fin_side.kind)
         OP_MUL: begin
            res_sel = fin_side.mul_res;
            ovf_sel = fin_side.mul_ovf;
         end
         OP_DIV: begin
            if (fin_side.dbz) begin
               res_sel = 32'd0;
               dbz_sel = 1'b1;
            end else begin
               res_sel = div_res;
               ovf_sel = div_ovf;
            end
         end
         default: res_sel = fin_side.res_simple;
      endcase

      rsp_data_in = {dbz_sel, ovf_sel, fin_side.gt, fin_side.eq, fin_side.lt, res_sel};
   end

   // output register frees the pipeline whenever it is empty or being taken
   assign pipe_en = !rsp_vld_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_vld_ff <= dv_vld[NUM_W];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign req_tready = pipe_en;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff};

   // ---------------- checks
   `FPA_ASSERT(a_flags_onehot, clock, reset,
      rsp_tvalid |-> $onehot(rsp_tdata[34:32]), "compare flags not one-hot")
   `FPA_ASSERT_NEVER(a_dbz_ovf, clock, reset,
      rsp_tvalid && rsp_tdata[36] && rsp_tdata[35], "divide by zero with overflow")
   `FPA_ASSERT(a_dbz_zero, clock, reset,
      (rsp_tvalid && rsp_tdata[36]) |-> (rsp_tdata[31:0] == 32'd0),
      "divide by zero result not cleared")
   `FPA_ASSERT(a_stall_holds, clock, reset,
      !pipe_en |=> ($stable(s1_vld_ff) && $stable(dv_vld[NUM_W])),
      "pipeline moved during stall")

endmodule

// ===== tb/fixed_point_q24_8_alu_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_top_tb
// drives directed and random alu operations through the request stream with
// random idling on both sides; each response is checked field by field
// against an exact fixed-point model of the alu held in this bench
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_top_tb;
   import fpa_pkg::*;

   localparam int FRAC = FPA_FRAC_BITS_DEF;
   localparam int LATENCY = 35 + FRAC;
   localparam logic [3:0] OP_SPARE_LO = 4'd10;
   localparam logic [3:0] OP_SPARE_HI = 4'd15;

   typedef struct packed {
      logic [3:0]  kind;
      logic [31:0] opa;
      logic [31:0] opb;
   } alu_op_type;

   typedef struct packed {
      logic [31:0] res;
      logic        lt;
      logic        eq;
      logic        gt;
      logic        ovf;
      logic        dbz;
   } alu_res_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // [31:0] operand_a, [63:32] operand_b
   logic [3:0]  req_tuser;   // [3:0] kind
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // [31:0] result, lt, eq, gt, ovf, dbz, zero pad

   alu_op_type  pending_ops[$];
   alu_res_type expected_res[$];
   bit       stim_done;
   bit       quiet_tail;
   int       mismatches;
   int       req_gap;
   int       rsp_gap;

   fixed_point_q24_8_alu_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // clamp to the signed 32-bit range
   function automatic logic [32:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return {1'b1, 32'h7fffffff};
      if (v < -64'sd2147483648) return {1'b1, 32'h80000000};
      return {1'b0, v[31:0]};
   endfunction

   function automatic alu_res_type alu_predict(input alu_op_type op);
      alu_res_type r;
      longint     a, b, p, q, rem, num;
      logic [32:0] sat;
      a = longint'(signed'(op.opa));
      b = longint'(signed'(op.opb));
      r = '0;
      r.lt = a < b;
      r.eq = a == b;
      r.gt = a > b;
      case (op.kind)
         OP_ADD: r.res = op.opa + op.opb;
         OP_SUB: r.res = op.opa - op.opb;
         OP_MUL: begin
            // ceiling of the product over 2^frac; >>> floors
            p = a * b + ((64'sd1 <<< FRAC) - 1);
            sat = clamp32(p >>> FRAC);
            {r.ovf, r.res} = sat;
         end
         OP_DIV: begin
            if (b == 0) begin
               r.dbz = 1'b1;
            end else begin
               num = a <<< FRAC;
               q = num / b;
               rem = num % b;
               if (rem != 0 && ((rem > 0) == (b > 0))) q = q + 1;
               sat = clamp32(q);
               {r.ovf, r.res} = sat;
            end
         end
         OP_MIN: r.res = (a < b) ? op.opa : op.opb;
         OP_MAX: r.res = (a > b) ? op.opa : op.opb;
         OP_INC: r.res = op.opa + 32'd1;
         OP_DEC: r.res = op.opa - 32'd1;
         OP_I2F: r.res = op.opa << FRAC;
         OP_F2I: r.res = $signed(op.opa) >>> FRAC;
         default: r.res = '0;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff - $urandom_range(0, 3);
         1: return 32'h80000000 + $urandom_range(0, 3);
         2: return $urandom_range(0, 1) ? $urandom_range(0, 4095)
                                        : -$urandom_range(0, 4095);
         3: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   task automatic push_op(input logic [3:0] k, input logic [31:0] a,
                          input logic [31:0] b);
      pending_ops.push_back('{kind: k, opa: a, opb: b});
   endtask

   // stimulus
   initial begin
      alu_op_type op;
      // directed: extremes, each operation, saturation, zero divisor, spare codes
      push_op(OP_ADD, 32'h7fffffff, 32'h00000001);
      push_op(OP_SUB, 32'h80000000, 32'h00000001);
      push_op(OP_MUL, 32'h7fffffff, 32'h7fffffff);
      push_op(OP_MUL, 32'h80000000, 32'h7fffffff);
      push_op(OP_MUL, 32'hfffffe80, 32'h00000080);
      push_op(OP_DIV, 32'h00000100, 32'h00000000);
      push_op(OP_DIV, 32'h7fffffff, 32'h00000001);
      push_op(OP_DIV, 32'h80000000, 32'hffffffff);
      push_op(OP_DIV, 32'hfffffd00, 32'h00000700);
      push_op(OP_DIV, 32'h00000300, 32'h00000700);
      push_op(OP_MIN, 32'h80000000, 32'h7fffffff);
      push_op(OP_MAX, 32'h80000000, 32'h7fffffff);
      push_op(OP_MIN, 32'h12345678, 32'h12345678);
      push_op(OP_INC, 32'h7fffffff, 32'h0);
      push_op(OP_DEC, 32'h80000000, 32'h0);
      push_op(OP_I2F, 32'hffffffff, 32'h0);
      push_op(OP_I2F, 32'h00ffffff, 32'h1);
      push_op(OP_F2I, 32'hffffff01, 32'h0);
      push_op(OP_F2I, 32'h80000000, 32'hffffffff);
      push_op(OP_SPARE_LO, 32'hffffffff, 32'h00000000);
      push_op(OP_SPARE_HI, 32'h00000000, 32'hffffffff);
      push_op(OP_ADD, 32'h0, 32'h0);
      repeat (650) begin
         op.kind = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                               : 4'($urandom_range(0, 9));
         op.opa = rand_operand();
         op.opb = ($urandom_range(0, 9) == 0) ? op.opa : rand_operand();
         if (op.kind == OP_DIV && $urandom_range(0, 15) == 0) op.opb = '0;
         pending_ops.push_back(op);
      end
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            req_gap <= $urandom_range(0, 6);
            req_tvalid <= 1'b0;
         end else if (pending_ops.size() > 0) begin
            alu_op_type op;
            op = pending_ops.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {op.opb, op.opa};
            req_tuser <= op.kind;
            expected_res.push_back(alu_predict(op));
            if (pending_ops.size() < 80) quiet_tail <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
            stim_done <= 1'b1;
         end
      end
   end

   // monitor with random back-pressure on the response side
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            alu_res_type got, want;
            got = '{res: rsp_tdata[31:0], lt: rsp_tdata[32], eq: rsp_tdata[33],
                    gt: rsp_tdata[34], ovf: rsp_tdata[35], dbz: rsp_tdata[36]};
            if (expected_res.size() == 0) begin
               $display("%0t: unexpected response %h", $time, rsp_tdata);
               mismatches++;
            end else begin
               want = expected_res.pop_front();
               if (got !== want || rsp_tdata[39:37] !== 3'b000) begin
                  $display("%0t: mismatch expected res=%h lt=%b eq=%b gt=%b ovf=%b dbz=%b",
                           $time, want.res, want.lt, want.eq, want.gt, want.ovf,
                           want.dbz);
                  $display("%0t:          actual   res=%h lt=%b eq=%b gt=%b ovf=%b dbz=%b",
                           $time, got.res, got.lt, got.eq, got.gt, got.ovf, got.dbz);
                  mismatches++;
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_tready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            rsp_gap <= $urandom_range(0, 6);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // reset and end of run
   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      stim_done = 1'b0;
      quiet_tail = 1'b0;
      mismatches = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done && expected_res.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/fpa_pkg.sv
rtl/fpa_mul.sv
rtl/fpa_div_step.sv
rtl/fixed_point_q24_8_alu_top.sv
tb/fixed_point_q24_8_alu_top_tb.sv
